/* hdl/console_line_editor_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the console line editor
// Short forms for same-cycle and next-cycle implication checks.
// ---------------------------------------------------------------------------
`ifndef CONSOLE_LINE_EDITOR_MACROS_SVH
`define CONSOLE_LINE_EDITOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cle_pkg.sv */
// ---------------------------------------------------------------------------
// Console line editor package
// Byte codes, result kinds, widths and shared types.
// ---------------------------------------------------------------------------
package cle_pkg;

    // Field widths of the result request.
    localparam int BYTE_W = 8;
    localparam int CHAR_W = 7;
    localparam int CNT_W  = 6;
    localparam int KIND_W = 2;

    // Result kinds.
    localparam logic [KIND_W-1:0] K_ECHO     = 2'd0;
    localparam logic [KIND_W-1:0] K_LINE     = 2'd1;
    localparam logic [KIND_W-1:0] K_TOO_LONG = 2'd2;

    // Character codes.
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

    // Class of a received byte.
    typedef enum logic [1:0] {
        C_NONE,
        C_PRINT,
        C_ERASE,
        C_EOL
    } t_cmd;

    // Write request into the line store.
    typedef struct packed {
        logic              en;
        logic [CNT_W-1:0]  addr;
        logic [CHAR_W-1:0] data;
    } t_store_wr;

endpackage

/* hdl/cle_if.sv */
// ---------------------------------------------------------------------------
// Console line editor channels
// Valid/ready channels for received bytes, results and configuration.
// ---------------------------------------------------------------------------

// Received byte channel.
interface cle_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel.
interface cle_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [5:0] line_length;
    logic       last;

    modport source (output valid, output kind, output data_byte, output line_length,
                    output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input line_length,
                    input last, output ready);
endinterface

// Configuration write channel.
interface cle_cfg_if;
    logic valid;
    logic ready;
    logic echo_enable;

    modport source (output valid, output echo_enable, input ready);
    modport sink   (input valid, input echo_enable, output ready);
endinterface

/* hdl/cle_decode.sv */
// ---------------------------------------------------------------------------
// Byte classifier
// Sorts a received byte into printable, erase, line end or ignored.
// ---------------------------------------------------------------------------
module cle_decode
    import cle_pkg::*;
(
    input  logic [BYTE_W-1:0] i_byte,
    output t_cmd              o_cmd
);

    // Line ends, erase keys and the printable range; all else is ignored.
    always_comb begin
        case (i_byte) inside
            CH_CR, CH_LF:      o_cmd = C_EOL;
            CH_BS, CH_DEL:     o_cmd = C_ERASE;
            [CH_SP:CH_TILDE]:  o_cmd = C_PRINT;
            default:           o_cmd = C_NONE;
        endcase
    end

endmodule

/* hdl/cle_store.sv */
// ---------------------------------------------------------------------------
// Line store
// Single-port-write memory of line characters with a registered read.
// ---------------------------------------------------------------------------
module cle_store
    import cle_pkg::*;
#(
    parameter  int DEPTH = 31,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  t_store_wr         i_wr,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [CHAR_W-1:0] o_rd_data
);

    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rd_data;

    // Write at the append position; read the addressed entry every cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/console_line_editor.sv */
// ---------------------------------------------------------------------------
// Console line editor
// Builds a command line from received bytes, echoes edits and streams out
// the finished line through one shared result register.
// ---------------------------------------------------------------------------
//  Channel  | Dir | Payload                              | Handshake
//  i_rx     | in  | rx_byte                              | valid/ready
//  o_res    | out | kind, data_byte, line_length, last   | valid/ready
//  i_cfg    | in  | echo_enable                          | valid/ready, always ready
//
//  A byte is taken only in the idle state, once every result of the last byte
//  is in the result register; a byte without results leaves the block ready in
//  the next cycle. Echo and report results go straight to the result register;
//  line characters pass S_FETCH and S_LINE, since the store read is registered.
//  A stalled result register stalls the sequencer and, in turn, the input.
//  Reset clears the count and the overflow flag and sets echo_enable to one.
// ---------------------------------------------------------------------------
`include "console_line_editor_macros.svh"

module console_line_editor
    import cle_pkg::*;
#(
    parameter  int LINE_MAX = 32,
    localparam int DEPTH    = LINE_MAX - 1,
    localparam int AW       = $clog2(DEPTH)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cle_rx_if.sink    i_rx,
    cle_res_if.source o_res,
    cle_cfg_if.sink   i_cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ECHO,
        S_FETCH,
        S_LINE
    } t_state;

    typedef enum logic [1:0] {
        J_CHAR,
        J_ERASE,
        J_TOO_LONG,
        J_CRLF
    } t_job;

    t_state              r_state, n_state;
    t_job                r_job, n_job;
    logic [1:0]          r_step, n_step;
    logic [AW-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_len, n_len;
    logic                r_ovf, n_ovf;
    logic                r_echo, n_echo;
    logic [BYTE_W-1:0]   r_char, n_char;
    logic                r_out_valid, n_out_valid;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [BYTE_W-1:0]   r_data, n_data;
    logic [CNT_W-1:0]    r_res_len, n_res_len;
    logic                r_last, n_last;

    t_cmd                rx_cmd;
    logic                rx_fire;
    logic                out_free;
    logic                line_last;
    t_store_wr           store_wr;
    logic [CHAR_W-1:0]   rd_data;

    cle_decode u_decode (
        .i_byte (i_rx.rx_byte),
        .o_cmd  (rx_cmd)
    );

    cle_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr      (store_wr),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    // Handshakes.
    assign i_rx.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign rx_fire     = i_rx.valid && i_rx.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign line_last   = (CNT_W'(r_idx) == r_len - CNT_W'(1));

    // Append a printable byte while the line has room.
    always_comb begin
        store_wr.en   = rx_fire && (rx_cmd == C_PRINT) && (r_count < CNT_W'(DEPTH));
        store_wr.addr = r_count;
        store_wr.data = i_rx.rx_byte[CHAR_W-1:0];
    end

    // Sequencer: line state updates on a request and one result per free slot.
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_step      = r_step;
        n_idx       = r_idx;
        n_count     = r_count;
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_echo      = r_echo;
        n_char      = r_char;
        n_out_valid = r_out_valid && !o_res.ready;
        n_kind      = r_kind;
        n_data      = r_data;
        n_res_len   = r_res_len;
        n_last      = r_last;

        if (i_cfg.valid) begin
            n_echo = i_cfg.echo_enable;
        end

        case (r_state)
            S_IDLE: begin
                if (rx_fire) begin
                    n_step = 2'd0;
                    n_char = i_rx.rx_byte;
                    case (rx_cmd)
                        C_EOL: begin
                            if (r_ovf) begin
                                n_ovf   = 1'b0;
                                n_count = '0;
                                n_job   = J_TOO_LONG;
                                n_state = S_ECHO;
                            end else if (r_count != '0) begin
                                n_len   = r_count;
                                n_count = '0;
                                n_idx   = '0;
                                n_job   = J_CRLF;
                                n_state = r_echo ? S_ECHO : S_FETCH;
                            end
                        end
                        C_ERASE: begin
                            if (r_count != '0) begin
                                n_count = r_count - CNT_W'(1);
                                n_job   = J_ERASE;
                                if (r_echo) begin
                                    n_state = S_ECHO;
                                end
                            end
                        end
                        C_PRINT: begin
                            if (r_count < CNT_W'(DEPTH)) begin
                                n_count = r_count + CNT_W'(1);
                                n_job   = J_CHAR;
                                if (r_echo) begin
                                    n_state = S_ECHO;
                                end
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_ECHO: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = K_ECHO;
                    n_res_len   = '0;
                    n_last      = 1'b1;
                    n_step      = r_step + 2'd1;
                    case (r_job)
                        J_CHAR: begin
                            n_data  = r_char;
                            n_state = S_IDLE;
                        end
                        J_TOO_LONG: begin
                            n_kind  = K_TOO_LONG;
                            n_data  = '0;
                            n_state = S_IDLE;
                        end
                        J_ERASE: begin
                            n_data = (r_step == 2'd1) ? CH_SP : CH_BS;
                            n_last = (r_step == 2'd2);
                            if (r_step == 2'd2) begin
                                n_state = S_IDLE;
                            end
                        end
                        J_CRLF: begin
                            n_data = (r_step == 2'd0) ? CH_CR : CH_LF;
                            n_last = 1'b0;
                            if (r_step == 2'd1) begin
                                n_state = S_FETCH;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // The store reads the current index in this cycle; S_LINE uses the data.
            S_FETCH: begin
                n_state = S_LINE;
            end

            S_LINE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = K_LINE;
                    n_data      = {1'b0, rd_data};
                    n_res_len   = r_len;
                    n_last      = line_last;
                    if (line_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_FETCH;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_echo      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_echo      <= n_echo;
            r_out_valid <= n_out_valid;
        end
        r_job     <= n_job;
        r_step    <= n_step;
        r_idx     <= n_idx;
        r_len     <= n_len;
        r_char    <= n_char;
        r_kind    <= n_kind;
        r_data    <= n_data;
        r_res_len <= n_res_len;
        r_last    <= n_last;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_kind;
    assign o_res.data_byte   = r_data;
    assign o_res.line_length = r_res_len;
    assign o_res.last        = r_last;

    // Checks on the line bookkeeping.
    `CLE_ASSERT_SAME(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "line count beyond store depth")
    `CLE_ASSERT_NEXT(a_eol_starts_line, i_clk, i_rst_n, rx_fire && rx_cmd == C_EOL && !r_ovf && r_count != '0, r_count == '0 && r_state != S_IDLE, "line end did not start line output")
    `CLE_ASSERT_SAME(a_line_len_nonzero, i_clk, i_rst_n, r_out_valid && r_kind == K_LINE, r_res_len != '0, "line result with zero length")
    `CLE_ASSERT_NEXT(a_full_sets_ovf, i_clk, i_rst_n, rx_fire && rx_cmd == C_PRINT && r_count == CNT_W'(DEPTH), r_ovf, "full line did not set overflow")

endmodule

/* bench/cle_line_checker.sv */
// ---------------------------------------------------------------------------
// Console line editor checker
// Watches the received-byte, configuration and result channels. It keeps its
// own copy of the line, the count, the overflow flag and echo_enable, predicts
// the console output for each accepted byte request, and compares every
// accepted result request with the oldest prediction, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module cle_line_checker
    import cle_pkg::*;
#(
    parameter int LINE_MAX = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    input  logic              i_rx_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic              i_cfg_echo_enable,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [KIND_W-1:0] i_res_kind,
    input  logic [BYTE_W-1:0] i_res_data_byte,
    input  logic [CNT_W-1:0]  i_res_line_length,
    input  logic              i_res_last,
    output int                o_fail_count,
    output int                o_pending
);

    // One predicted result request on the console output.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_byte;
        logic [CNT_W-1:0]  line_length;
        logic              last;
    } t_console_out;

    // Mirror of the editor state.
    logic [CHAR_W-1:0] line_chars [LINE_MAX-1];
    logic [CNT_W-1:0]  char_count;
    logic              too_long;
    logic              echo_on;

    t_console_out console_out_q [$];
    t_console_out oldest_out;

    // Queue one predicted result; the last flag is set once the byte is done.
    function automatic void expect_out(input logic [KIND_W-1:0] kind,
                                       input logic [BYTE_W-1:0] data,
                                       input logic [CNT_W-1:0]  len);
        console_out_q.push_back('{kind, data, len, 1'b0});
    endfunction

    // Work out what one received byte does to the line and what it prints.
    function automatic void apply_rx_byte(input logic [BYTE_W-1:0] ch);
        int first;
        int i;
        first = console_out_q.size();
        if (ch == CH_CR || ch == CH_LF) begin
            if (too_long) begin
                // A dropped character turns the whole line into one report.
                too_long   = 1'b0;
                char_count = '0;
                expect_out(K_TOO_LONG, 8'h00, '0);
            end else if (char_count != 0) begin
                if (echo_on) begin
                    expect_out(K_ECHO, CH_CR, '0);
                    expect_out(K_ECHO, CH_LF, '0);
                end
                for (i = 0; i < char_count; i++) begin
                    expect_out(K_LINE, {1'b0, line_chars[i]}, char_count);
                end
                char_count = '0;
            end
        end else if (ch == CH_BS || ch == CH_DEL) begin
            // Erase leaves the overflow flag alone.
            if (char_count != 0) begin
                char_count = char_count - 1'b1;
                if (echo_on) begin
                    expect_out(K_ECHO, CH_BS, '0);
                    expect_out(K_ECHO, CH_SP, '0);
                    expect_out(K_ECHO, CH_BS, '0);
                end
            end
        end else if (ch >= CH_SP && ch <= CH_TILDE) begin
            if (char_count < LINE_MAX - 1) begin
                line_chars[char_count] = ch[CHAR_W-1:0];
                char_count             = char_count + 1'b1;
                if (echo_on) begin
                    expect_out(K_ECHO, ch, '0);
                end
            end else begin
                too_long = 1'b1;
            end
        end
        if (console_out_q.size() > first) begin
            console_out_q[console_out_q.size()-1].last = 1'b1;
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    // Results are checked before the byte request of the same edge is applied,
    // so a byte can never be matched against its own results within the same cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_count   = '0;
            too_long     = 1'b0;
            echo_on      = 1'b1;
            o_fail_count = 0;
            console_out_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (console_out_q.size() == 0) begin
                    $error("unexpected result: kind %0d data 0x%0h length %0d last %0d",
                           i_res_kind, i_res_data_byte, i_res_line_length, i_res_last);
                    o_fail_count++;
                end else begin
                    oldest_out = console_out_q.pop_front();
                    check_field("kind", oldest_out.kind, i_res_kind);
                    check_field("data_byte", oldest_out.data_byte, i_res_data_byte);
                    check_field("line_length", oldest_out.line_length, i_res_line_length);
                    check_field("last", oldest_out.last, i_res_last);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                echo_on = i_cfg_echo_enable;
            end
            if (i_rx_valid && i_rx_ready) begin
                apply_rx_byte(i_rx_byte);
            end
        end
        o_pending = console_out_q.size();
    end

endmodule

/* bench/console_line_editor_tb.sv */
// ---------------------------------------------------------------------------
// Console line editor testbench
// Drives received bytes and echo_enable writes into the editor with random
// gaps on both sides, a long stall of the result channel and drained pauses
// between phases. A directed opening covers the byte classes and edge cases;
// random command lines follow, some long enough to overflow the line.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module console_line_editor_tb;
    import cle_pkg::*;

    localparam int LINE_MAX     = 32;
    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 9;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cle_rx_if  rx_ch ();
    cle_res_if res_ch ();
    cle_cfg_if cfg_ch ();

    int fail_count;
    int pending_results;
    int rx_sent     = 0;
    int cycle_count = 0;
    bit no_idle     = 1'b0;
    bit hold_go     = 1'b0;
    bit hold_off    = 1'b0;

    logic [BYTE_W-1:0] opening_bytes [$] = '{
        CH_CR, CH_LF, CH_BS, CH_DEL, 8'h00, 8'h1F, 8'h80, 8'hFF, 8'h1B,
        CH_SP, CH_TILDE, 8'h41, CH_DEL, 8'h5A, CH_BS, 8'h61, CH_CR, CH_LF,
        CH_TILDE, CH_LF
    };
    logic [BYTE_W-1:0] quiet_bytes [$] = '{8'h31, 8'h32, CH_BS, CH_TILDE, CH_CR};

    console_line_editor #(
        .LINE_MAX (LINE_MAX)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    cle_line_checker #(
        .LINE_MAX (LINE_MAX)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx_valid        (rx_ch.valid),
        .i_rx_ready        (rx_ch.ready),
        .i_rx_byte         (rx_ch.rx_byte),
        .i_cfg_valid       (cfg_ch.valid),
        .i_cfg_ready       (cfg_ch.ready),
        .i_cfg_echo_enable (cfg_ch.echo_enable),
        .i_res_valid       (res_ch.valid),
        .i_res_ready       (res_ch.ready),
        .i_res_kind        (res_ch.kind),
        .i_res_data_byte   (res_ch.data_byte),
        .i_res_line_length (res_ch.line_length),
        .i_res_last        (res_ch.last),
        .o_fail_count      (fail_count),
        .o_pending         (pending_results)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL console_line_editor");
            $finish;
        end
    end

    // Long stall of the result channel, started once by the stimulus.
    initial begin : result_hold
        wait (hold_go);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Result receiver: a random stall before each request is taken, none while no_idle is set.
    initial begin : result_sink
        int stall;
        stall        = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n || hold_off || stall != 0) begin
                res_ch.ready <= 1'b0;
                if (i_rst_n && !hold_off && stall != 0) begin
                    stall--;
                end
            end else begin
                res_ch.ready <= 1'b1;
            end
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) begin
                stall = no_idle ? 0 : $urandom_range(0, 3);
            end
        end
    end

    // Offer one byte request after a random gap and hold it until taken.
    task automatic send_rx(input logic [BYTE_W-1:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            rx_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        rx_sent++;
    endtask

    // Stop offering, wait for every predicted result, then let the block settle.
    task automatic wait_drained();
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_echo(input logic value);
        @(negedge i_clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.echo_enable <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One typed command line: mostly printable text with the odd erase or
    // stray byte, closed by CR, LF or CR LF, or left open. Some lines run past the store.
    task automatic type_line();
        int n_chars;
        int k;
        no_idle = ($urandom_range(0, 3) == 0);
        n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(29, 36)
                                              : $urandom_range(0, 10);
        for (k = 0; k < n_chars; k++) begin
            case ($urandom_range(0, 15))
                0: send_rx($urandom_range(0, 1) ? CH_BS : CH_DEL);
                1: send_rx(BYTE_W'($urandom_range(0, 255)));
                default: send_rx(BYTE_W'($urandom_range(CH_SP, CH_TILDE)));
            endcase
        end
        case ($urandom_range(0, 3))
            0: send_rx(CH_CR);
            1: send_rx(CH_LF);
            2: begin
                send_rx(CH_CR);
                send_rx(CH_LF);
            end
            default: begin
                // Unterminated line: the next one carries on from here.
            end
        endcase
    endtask

    // Main stimulus and verdict.
    initial begin
        i_rst_n            = 1'b0;
        rx_ch.valid        = 1'b0;
        rx_ch.rx_byte      = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.echo_enable = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening with echo at its reset value.
        foreach (opening_bytes[i]) send_rx(opening_bytes[i]);
        wait_drained();

        // Editing without echo: only the line itself comes out.
        write_echo(1'b0);
        foreach (quiet_bytes[i]) send_rx(quiet_bytes[i]);
        wait_drained();

        // Random lines; the result channel stalls for a long stretch first.
        write_echo(1'b1);
        hold_go = 1'b1;
        while (rx_sent < 120) type_line();
        wait_drained();

        write_echo(1'b0);
        while (rx_sent < 210) type_line();
        wait_drained();

        write_echo(1'b1);
        while (rx_sent < 300) type_line();
        wait_drained();

        write_echo(1'($urandom_range(0, 1)));
        while (rx_sent < 365) type_line();
        wait_drained();

        if (fail_count == 0 && pending_results == 0) begin
            $display("PASS console_line_editor");
        end else begin
            $display("FAIL console_line_editor");
        end
        $finish;
    end

endmodule
